/* src/ttsc_pkg.sv */
// ----------------------------------------------------------------------------
// ttsc_pkg: shared types and constants of the text terminal screen controller
// Character codes, command kinds and the command record that runs from the
// front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package ttsc_pkg;

  // Character codes
  localparam logic [6:0] SPACE_CODE   = 7'd32;   // also the case bit
  localparam logic [6:0] LOWER_FIRST  = 7'd96;
  localparam logic [6:0] DEL_CODE     = 7'd127;
  localparam logic [6:0] CODE_BS      = 7'd8;
  localparam logic [6:0] CODE_LF      = 7'd10;
  localparam logic [6:0] CODE_VT      = 7'd11;
  localparam logic [6:0] CODE_CR      = 7'd13;
  localparam logic [6:0] CODE_CAN     = 7'd24;
  localparam logic [6:0] CODE_EM      = 7'd25;
  localparam logic [6:0] CODE_SUB     = 7'd26;
  localparam logic [6:0] CODE_FS      = 7'd28;
  localparam logic [6:0] CODE_GS      = 7'd29;
  localparam logic [6:0] CODE_RS      = 7'd30;
  localparam logic [6:0] CODE_US      = 7'd31;

  // Row the home-down code moves to, clamped to the store
  localparam logic [5:0] HOME_DOWN_ROW = 6'd24;

  // Request operation codes
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Command kinds for the back end
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_NONE  = 2'd0;  // cursor only, maybe scroll
  localparam cmd_kind_t CMD_PUT   = 2'd1;  // store one code, maybe scroll
  localparam cmd_kind_t CMD_READ  = 2'd2;  // read one in-range cell
  localparam cmd_kind_t CMD_ERASE = 2'd3;  // fill spaces from a cell on

  typedef struct packed {
    cmd_kind_t  kind;
    logic       scroll;     // scroll up one row after the store write
    logic       erase_all;  // erase to end of screen, else end of row
    logic [6:0] code;       // code to store
    logic [4:0] row;        // target cell row
    logic [6:0] col;        // target cell column
    logic [6:0] cur_col;    // cursor after the request
    logic [4:0] cur_row;
  } cmd_t;

endpackage

/* src/ttsc_in_if.sv */
// ----------------------------------------------------------------------------
// ttsc_in_if: request channel of the screen controller
// Valid/ready handshake carrying one receive or read request.
// ----------------------------------------------------------------------------
interface ttsc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [6:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;

  modport source (output valid, output operation, output char_code,
                  output read_row, output read_col, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input read_row, input read_col, output ready);
endinterface

/* src/ttsc_out_if.sv */
// ----------------------------------------------------------------------------
// ttsc_out_if: result channel of the screen controller
// Valid/ready handshake carrying the read cell and the cursor position.
// ----------------------------------------------------------------------------
interface ttsc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cell_char;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;

  modport source (output valid, output cell_char, output cursor_col,
                  output cursor_row, input ready);
  modport sink   (input valid, input cell_char, input cursor_col,
                  input cursor_row, output ready);
endinterface

/* src/ttsc_front.sv */
// ----------------------------------------------------------------------------
// ttsc_front: request decoder and cursor tracker
// Classifies each request, moves the cursor and pushes one command for
// the back end into the command queue.
// ----------------------------------------------------------------------------
module ttsc_front #(
  parameter int COLUMNS = 72,
  parameter int ROWS    = 25
) (
  input  logic            clk,
  input  logic            rst,
  ttsc_in_if.sink         cmd,
  input  logic            clearing,
  output logic            push_valid,
  input  logic            push_ready,
  output ttsc_pkg::cmd_t  push_data
);

  localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
  localparam logic [5:0] ROW_LIMIT = 6'(ROWS);
  localparam logic [5:0] LAST_ROW  = 6'(ROWS - 1);

  logic [6:0] cur_col;
  logic [4:0] cur_row;
  logic [7:0] col_next;
  logic [5:0] row_next;
  logic       line_feed;
  logic [6:0] folded;

  // Requests wait while the store is being cleared after reset
  assign cmd.ready  = push_ready && !clearing;
  assign push_valid = cmd.valid && !clearing;

  assign folded = (cmd.char_code >= ttsc_pkg::LOWER_FIRST &&
                   cmd.char_code != ttsc_pkg::DEL_CODE)
                  ? (cmd.char_code & ~ttsc_pkg::SPACE_CODE) : cmd.char_code;

  // Decode and cursor update
  always_comb begin
    col_next            = {1'b0, cur_col};
    row_next            = {1'b0, cur_row};
    line_feed           = 1'b0;
    push_data.kind      = ttsc_pkg::CMD_NONE;
    push_data.scroll    = 1'b0;
    push_data.erase_all = 1'b0;
    push_data.code      = folded;
    push_data.row       = cur_row;
    push_data.col       = cur_col;

    if (cmd.operation == ttsc_pkg::OP_READ) begin
      push_data.row = cmd.read_row;
      push_data.col = cmd.read_col;
      if ({1'b0, cmd.read_row} < ROW_LIMIT && {1'b0, cmd.read_col} < COL_LIMIT) begin
        push_data.kind = ttsc_pkg::CMD_READ;
      end
    end else if (cmd.char_code >= ttsc_pkg::SPACE_CODE) begin
      if (cmd.char_code != ttsc_pkg::DEL_CODE) begin
        push_data.kind = ttsc_pkg::CMD_PUT;
        col_next       = col_next + 8'd1;
      end
    end else begin
      case (cmd.char_code)
        ttsc_pkg::CODE_LF:  line_feed = 1'b1;
        ttsc_pkg::CODE_VT:  row_next  = row_next + 6'd1;
        ttsc_pkg::CODE_CR:  col_next  = 8'd0;
        ttsc_pkg::CODE_CAN: col_next  = col_next + 8'd1;
        ttsc_pkg::CODE_BS,
        ttsc_pkg::CODE_EM: begin
          if (col_next != 8'd0) col_next = col_next - 8'd1;
        end
        ttsc_pkg::CODE_SUB: begin
          if (row_next != 6'd0) row_next = row_next - 6'd1;
        end
        ttsc_pkg::CODE_FS: begin
          col_next = 8'd0;
          row_next = ttsc_pkg::HOME_DOWN_ROW;
        end
        ttsc_pkg::CODE_GS: begin
          col_next = 8'd0;
          row_next = 6'd0;
        end
        ttsc_pkg::CODE_RS: push_data.kind = ttsc_pkg::CMD_ERASE;
        ttsc_pkg::CODE_US: begin
          push_data.kind      = ttsc_pkg::CMD_ERASE;
          push_data.erase_all = 1'b1;
        end
        default: ;
      endcase
    end

    // Column overflow wraps with a line feed
    if (col_next >= COL_LIMIT) begin
      col_next  = 8'd0;
      line_feed = 1'b1;
    end
    // Line feed past the bottom row scrolls
    if (line_feed) begin
      if (row_next + 6'd1 >= ROW_LIMIT) begin
        push_data.scroll = 1'b1;
        row_next         = LAST_ROW;
      end else begin
        row_next = row_next + 6'd1;
      end
    end
    if (row_next >= ROW_LIMIT) row_next = LAST_ROW;

    push_data.cur_col = col_next[6:0];
    push_data.cur_row = row_next[4:0];
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= 7'd0;
      cur_row <= 5'd0;
    end else if (cmd.valid && cmd.ready) begin
      cur_col <= push_data.cur_col;
      cur_row <= push_data.cur_row;
    end
  end

endmodule

/* src/ttsc_queue.sv */
// ----------------------------------------------------------------------------
// ttsc_queue: command queue between front and back end
// Four-entry FIFO of decoded commands.
// ----------------------------------------------------------------------------
module ttsc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  ttsc_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ttsc_pkg::cmd_t  pop_data
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  ttsc_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != (PW + 1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + (PW + 1)'(1);
      else if (do_pop && !do_push) count <= count - (PW + 1)'(1);
    end
  end

endmodule

/* src/ttsc_back.sv */
// ----------------------------------------------------------------------------
// ttsc_back: screen store and command executor
// Owns the character store, carries out store writes, erase sweeps, the
// scroll copy and cell reads, and holds the result register.
// ----------------------------------------------------------------------------
module ttsc_back #(
  parameter int COLUMNS = 72,
  parameter int ROWS    = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  ttsc_pkg::cmd_t  pop_data,
  output logic            clearing,
  ttsc_out_if.source      rsp
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);
  localparam logic [AW-1:0] FILL_FIRST = AW'(CELLS - COLUMNS);

  localparam logic [2:0] ST_ERASE  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [6:0]     store [CELLS];
  logic [6:0]     rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [6:0]     mem_wdata;
  logic [AW-1:0]  mem_raddr;

  logic [2:0]     state;
  logic [AW-1:0]  sweep;
  logic [AW-1:0]  sweep_last;
  logic           pend;
  logic [AW-1:0]  pend_addr;
  logic           pend_space;
  logic [6:0]     res_cell;
  logic [6:0]     res_col;
  logic [4:0]     res_row;
  logic           out_valid;
  logic [6:0]     out_cell;
  logic [6:0]     out_col;
  logic [4:0]     out_row;
  logic           load_out;
  logic [AW-1:0]  lin_addr;
  logic [AW-1:0]  row_last;

  assign lin_addr  = AW'(pop_data.row) * AW'(COLUMNS) + AW'(pop_data.col);
  assign row_last  = AW'(pop_data.row) * AW'(COLUMNS) + AW'(COLUMNS - 1);
  assign pop_ready = state == ST_IDLE;
  assign load_out  = (state == ST_DONE) && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.cell_char  = out_cell;
  assign rsp.cursor_col = out_col;
  assign rsp.cursor_row = out_row;

  // Store port control: delayed scroll write first, else the state's write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = ttsc_pkg::SPACE_CODE;
    mem_raddr = (state == ST_SCROLL) ? sweep + AW'(COLUMNS) : lin_addr;
    if (pend) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = pend_space ? ttsc_pkg::SPACE_CODE : rdata;
    end else begin
      case (state)
        ST_ERASE: mem_we = 1'b1;
        ST_IDLE: begin
          if (pop_valid && pop_data.kind == ttsc_pkg::CMD_PUT) begin
            mem_we    = 1'b1;
            mem_waddr = lin_addr;
            mem_wdata = pop_data.code;
          end
        end
        default: ;
      endcase
    end
  end

  // Screen store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    rdata <= store[mem_raddr];
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ERASE;
      sweep      <= '0;
      sweep_last <= LAST_ADDR;
      clearing   <= 1'b1;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend <= state == ST_SCROLL;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;

      case (state)
        // Fill spaces up to sweep_last; also the clearing pass after reset
        ST_ERASE: begin
          sweep <= sweep + AW'(1);
          if (sweep == sweep_last) begin
            clearing <= 1'b0;
            state    <= clearing ? ST_IDLE : ST_DONE;
          end
        end

        ST_IDLE: begin
          if (pop_valid) begin
            res_cell <= 7'd0;
            res_col  <= pop_data.cur_col;
            res_row  <= pop_data.cur_row;
            sweep    <= (pop_data.kind == ttsc_pkg::CMD_ERASE) ? lin_addr : '0;
            case (pop_data.kind)
              ttsc_pkg::CMD_READ: state <= ST_READ;
              ttsc_pkg::CMD_ERASE: begin
                sweep_last <= pop_data.erase_all ? LAST_ADDR : row_last;
                state      <= ST_ERASE;
              end
              default: state <= pop_data.scroll ? ST_SCROLL : ST_DONE;
            endcase
          end
        end

        // Copy cells up one row, one a cycle, each written in the next cycle
        ST_SCROLL: begin
          pend_addr  <= sweep;
          pend_space <= sweep >= FILL_FIRST;
          sweep      <= sweep + AW'(1);
          if (sweep == LAST_ADDR) state <= ST_DONE;
        end

        ST_READ: begin
          res_cell <= rdata;
          state    <= ST_DONE;
        end

        // Hand the result over when the output register is free
        ST_DONE: begin
          if (load_out) begin
            out_cell  <= res_cell;
            out_col   <= res_col;
            out_row   <= res_row;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/text_terminal_screen_controller_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_screen_controller_unit: character terminal screen engine
// Keeps a ROWS x COLUMNS store of 7-bit codes and a cursor, carries out
// printable and control codes and answers cell reads.
//
//   channel  role    payload
//   cmd      sink    operation, char_code, read_row, read_col
//   rsp      source  cell_char, cursor_col, cursor_row
//
// After reset the store is swept to spaces, one cell a cycle, and no
// request is taken in that time. A request is taken into a four-deep
// command queue. The back end then carries out a cursor move, a store
// write or a read, and sweeps the store one cell a cycle for an erase or a
// scroll, a pace set by the single write port of the store.
// Requests keep being taken while the queue has room and while a result
// waits in the output register.
// ----------------------------------------------------------------------------
module text_terminal_screen_controller_unit #(
  parameter int COLUMNS = 72,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst,
  ttsc_in_if.sink    cmd,
  ttsc_out_if.source rsp
);

  logic            clearing;
  logic            push_valid;
  logic            push_ready;
  ttsc_pkg::cmd_t  push_data;
  logic            pop_valid;
  logic            pop_ready;
  ttsc_pkg::cmd_t  pop_data;

  // Front end: decode and cursor
  ttsc_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Command queue
  ttsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: store and results
  ttsc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .clearing  (clearing),
    .rsp       (rsp)
  );

endmodule
